// ===== sv/priority_quantum_thread_scheduler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUANTUM_THREAD_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_QUANTUM_THREAD_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTH
`define PQTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PQTS_IMPLY(label, cond, conseq, msg) \
    `PQTS_ASSERT(label, (cond) |-> (conseq), msg)
`else
`define PQTS_ASSERT(label, prop, msg)
`define PQTS_IMPLY(label, cond, conseq, msg)
`endif

`endif

// ===== sv/pqts_pkg.sv =====
// ----------------------------------------------------------------------------
// pqts_pkg
// Types and constants shared by the thread scheduler modules.
// ----------------------------------------------------------------------------
package pqts_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = SLOT_W + 1;
    localparam int IDX_W  = 4;
    localparam int NUM_Q  = 4;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [1:0] {
        ST_DEAD    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } status_e;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_EXIT    = 3'd1,
        CMD_YIELD   = 3'd2,
        CMD_TICK    = 3'd3,
        CMD_BLOCK   = 3'd4,
        CMD_UNBLOCK = 3'd5,
        CMD_KILL    = 3'd6,
        CMD_QUERY   = 3'd7
    } cmd_e;

    typedef enum logic [1:0] {
        RS_OK       = 2'd0,
        RS_NOFREE   = 2'd1,
        RS_NOTFOUND = 2'd2
    } res_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_PICK,
        S_FOUND,
        S_RD,
        S_RMW,
        S_FIN
    } state_e;

    typedef enum logic [1:0] {
        SC_FIND,
        SC_FIND_BLK,
        SC_CHOOSE
    } scan_e;

    typedef enum logic [1:0] {
        PM_EXIT,
        PM_Y0,
        PM_Y
    } pick_e;

    typedef struct packed {
        logic [1:0]  pri;
        logic [15:0] quantum;
        logic [31:0] ticks;
        logic [31:0] id;
    } rec_t;

    typedef logic [NUM_Q-1:0][15:0] quanta_t;
    typedef logic [SLOTS-1:0][1:0]  st_vec_t;

    typedef struct packed {
        logic    rd_en;
        slot_t   rd_addr;
        logic    wr_en;
        slot_t   wr_addr;
        rec_t    wr_rec;
        logic    sa_we;
        slot_t   sa_addr;
        status_e sa_val;
        logic    sb_we;
        slot_t   sb_addr;
        status_e sb_val;
    } tbl_req_t;

    // packed high to low, so status lands in the lowest bits
    typedef struct packed {
        logic [31:0]      found_run_ticks;
        logic [1:0]       found_priority;
        logic [1:0]       found_state;
        logic             resched_pending;
        logic [31:0]      current_id;
        logic [IDX_W-1:0] current_index;
        logic             has_current;
        logic             switched;
        logic [31:0]      new_id;
        logic [1:0]       status;
    } result_t;

endpackage

// ===== sv/pqts_table.sv =====
// ----------------------------------------------------------------------------
// pqts_table
// Slot record memory (one read, one write port), slot status flops, id marks.
// ----------------------------------------------------------------------------
module pqts_table (
    input  logic               clk,
    input  logic               rst_n,
    input  pqts_pkg::tbl_req_t req,
    output pqts_pkg::rec_t     rd_rec,
    output pqts_pkg::st_vec_t  st_vec
);

    pqts_pkg::rec_t              mem [pqts_pkg::SLOTS];
    pqts_pkg::rec_t              rd_reg;
    logic                        idv_reg;
    logic [pqts_pkg::SLOTS-1:0]  idw_reg;
    pqts_pkg::st_vec_t           st_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_rec;
        end
        if (req.rd_en)
        begin
            rd_reg  <= mem[req.rd_addr];
            idv_reg <= idw_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idw_reg <= '0;
            st_reg  <= '0;
        end
        else
        begin
            if (req.wr_en)
            begin
                idw_reg[req.wr_addr] <= 1'b1;
            end
            if (req.sa_we)
            begin
                st_reg[req.sa_addr] <= req.sa_val;
            end
            if (req.sb_we)
            begin
                st_reg[req.sb_addr] <= req.sb_val;
            end
        end
    end

    // slots never written read id zero
    always_comb
    begin
        rd_rec = rd_reg;
        if (!idv_reg)
        begin
            rd_rec.id = '0;
        end
    end

    assign st_vec = st_reg;

endmodule

// ===== sv/pqts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqts_ctrl
// Command sequencer: slot scans, pick, read-modify-write of slot records.
// ----------------------------------------------------------------------------
`include "priority_quantum_thread_scheduler_top_assert.svh"

module pqts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_command,
    input  logic [31:0]        in_thread_id,
    input  logic [7:0]         in_req_priority,
    input  pqts_pkg::quanta_t  quanta,
    input  logic               out_free,
    output logic               res_valid,
    output pqts_pkg::result_t  res,
    output pqts_pkg::tbl_req_t tbl_req,
    input  pqts_pkg::rec_t     rd_rec,
    input  pqts_pkg::st_vec_t  st_vec
);

    pqts_pkg::state_e state_reg, state_next;
    pqts_pkg::cmd_e   cmd_reg, cmd_next;
    logic [31:0]      tid_reg, tid_next;
    logic [7:0]       req_reg, req_next;
    logic             was_valid_reg, was_valid_next;
    pqts_pkg::slot_t  was_slot_reg, was_slot_next;
    logic             cur_valid_reg, cur_valid_next;
    pqts_pkg::slot_t  cur_slot_reg, cur_slot_next;
    logic [31:0]      cur_id_reg, cur_id_next;
    logic             active_reg, active_next;
    logic             resched_reg, resched_next;
    logic [31:0]      next_id_reg, next_id_next;
    logic [1:0]       rstat_reg, rstat_next;
    logic [31:0]      new_id_reg, new_id_next;
    logic [1:0]       fst_reg, fst_next;
    logic [1:0]       fpri_reg, fpri_next;
    logic [31:0]      fticks_reg, fticks_next;
    logic [pqts_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    pqts_pkg::slot_t  rd_idx_reg, rd_idx_next;
    pqts_pkg::scan_e  kind_reg, kind_next;
    pqts_pkg::slot_t  start_reg, start_next;
    logic             found_reg, found_next;
    pqts_pkg::slot_t  best_idx_reg, best_idx_next;
    pqts_pkg::rec_t   best_rec_reg, best_rec_next;
    pqts_pkg::pick_e  mode_reg, mode_next;

    // decode helpers
    logic                        dead_found;
    pqts_pkg::slot_t             dead_idx;
    pqts_pkg::status_e           f_st;
    logic                        found_ok;
    logic                        is_cur;
    logic                        pick_same;
    logic                        scan_done;
    logic                        scan_issue;
    logic [pqts_pkg::SUM_W-1:0]  wrap_sum;
    pqts_pkg::slot_t             scan_addr;
    pqts_pkg::status_e           ev_st;
    logic [1:0]                  new_pri;
    logic [15:0]                 tick_q;

    always_comb
    begin
        dead_found = 1'b0;
        dead_idx   = '0;
        for (int i = pqts_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (pqts_pkg::status_e'(st_vec[i]) == pqts_pkg::ST_DEAD)
            begin
                dead_found = 1'b1;
                dead_idx   = pqts_pkg::SLOT_W'(i);
            end
        end
        f_st      = pqts_pkg::status_e'(st_vec[best_idx_reg]);
        found_ok  = found_reg && (f_st != pqts_pkg::ST_DEAD);
        is_cur    = cur_valid_reg && (best_idx_reg == cur_slot_reg);
        pick_same = !found_reg || (best_idx_reg == cur_slot_reg);
        scan_issue = cnt_reg < pqts_pkg::CNT_W'(pqts_pkg::SLOTS);
        scan_done  = !scan_issue && !rd_pend_reg;
        wrap_sum = pqts_pkg::SUM_W'(start_reg) + pqts_pkg::SUM_W'(cnt_reg)
                 + pqts_pkg::SUM_W'(1);
        if (wrap_sum >= pqts_pkg::SUM_W'(pqts_pkg::SLOTS))
        begin
            wrap_sum = wrap_sum - pqts_pkg::SUM_W'(pqts_pkg::SLOTS);
        end
        scan_addr = (kind_reg == pqts_pkg::SC_CHOOSE) ? wrap_sum[pqts_pkg::SLOT_W-1:0]
                                                      : cnt_reg[pqts_pkg::SLOT_W-1:0];
        ev_st   = pqts_pkg::status_e'(st_vec[rd_idx_reg]);
        new_pri = (req_reg < 8'd4) ? req_reg[1:0] : 2'd1;
        tick_q  = (rd_rec.quantum == 16'd0) ? 16'd0 : rd_rec.quantum - 16'd1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pqts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pqts_pkg::S_DISP;
                end
            end
            pqts_pkg::S_DISP:
            begin
                unique case (cmd_reg)
                    pqts_pkg::CMD_CREATE:
                        state_next = pqts_pkg::S_FIN;
                    pqts_pkg::CMD_EXIT:
                        state_next = cur_valid_reg ? pqts_pkg::S_SCAN : pqts_pkg::S_FIN;
                    pqts_pkg::CMD_YIELD:
                        state_next = (!cur_valid_reg || active_reg) ? pqts_pkg::S_SCAN
                                                                    : pqts_pkg::S_FIN;
                    pqts_pkg::CMD_TICK:
                        state_next = (cur_valid_reg && active_reg) ? pqts_pkg::S_RD
                                                                   : pqts_pkg::S_FIN;
                    default:
                        state_next = pqts_pkg::S_SCAN;
                endcase
            end
            pqts_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = (kind_reg == pqts_pkg::SC_CHOOSE) ? pqts_pkg::S_PICK
                                                                   : pqts_pkg::S_FOUND;
                end
            end
            pqts_pkg::S_PICK:
            begin
                if (mode_reg == pqts_pkg::PM_Y && pick_same)
                begin
                    state_next = pqts_pkg::S_RD;
                end
                else
                begin
                    state_next = pqts_pkg::S_FIN;
                end
            end
            pqts_pkg::S_FOUND:
            begin
                state_next = pqts_pkg::S_FIN;
                if (found_ok && is_cur)
                begin
                    if (cmd_reg == pqts_pkg::CMD_KILL)
                    begin
                        state_next = pqts_pkg::S_SCAN;
                    end
                    else if (cmd_reg == pqts_pkg::CMD_BLOCK && active_reg &&
                             (f_st == pqts_pkg::ST_READY || f_st == pqts_pkg::ST_RUNNING))
                    begin
                        state_next = pqts_pkg::S_SCAN;
                    end
                end
            end
            pqts_pkg::S_RD:
                state_next = pqts_pkg::S_RMW;
            pqts_pkg::S_RMW:
                state_next = pqts_pkg::S_FIN;
            pqts_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = pqts_pkg::S_IDLE;
                end
            end
            default:
                state_next = pqts_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_next       = cmd_reg;
        tid_next       = tid_reg;
        req_next       = req_reg;
        was_valid_next = was_valid_reg;
        was_slot_next  = was_slot_reg;
        cur_valid_next = cur_valid_reg;
        cur_slot_next  = cur_slot_reg;
        cur_id_next    = cur_id_reg;
        active_next    = active_reg;
        resched_next   = resched_reg;
        next_id_next   = next_id_reg;
        rstat_next     = rstat_reg;
        new_id_next    = new_id_reg;
        fst_next       = fst_reg;
        fpri_next      = fpri_reg;
        fticks_next    = fticks_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        kind_next      = kind_reg;
        start_next     = start_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_rec_next  = best_rec_reg;
        mode_next      = mode_reg;
        tbl_req        = '0;
        in_ready       = (state_reg == pqts_pkg::S_IDLE);
        res_valid      = 1'b0;

        unique case (state_reg)
            pqts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = pqts_pkg::cmd_e'(in_command);
                    tid_next       = in_thread_id;
                    req_next       = in_req_priority;
                    was_valid_next = cur_valid_reg;
                    was_slot_next  = cur_slot_reg;
                    rstat_next     = pqts_pkg::RS_OK;
                    new_id_next    = '0;
                    fst_next       = '0;
                    fpri_next      = '0;
                    fticks_next    = '0;
                end
            end
            pqts_pkg::S_DISP:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                start_next = cur_valid_reg ? cur_slot_reg : '0;
                kind_next  = pqts_pkg::SC_CHOOSE;
                unique case (cmd_reg)
                    pqts_pkg::CMD_CREATE:
                    begin
                        if (!dead_found)
                        begin
                            rstat_next = pqts_pkg::RS_NOFREE;
                        end
                        else
                        begin
                            tbl_req.wr_en   = 1'b1;
                            tbl_req.wr_addr = dead_idx;
                            tbl_req.wr_rec  = '{pri: new_pri, quantum: quanta[new_pri],
                                                ticks: '0, id: next_id_reg};
                            tbl_req.sa_we   = 1'b1;
                            tbl_req.sa_addr = dead_idx;
                            tbl_req.sa_val  = pqts_pkg::ST_READY;
                            new_id_next     = next_id_reg;
                            next_id_next    = next_id_reg + 32'd1;
                            active_next     = 1'b1;
                        end
                    end
                    pqts_pkg::CMD_EXIT:
                    begin
                        tbl_req.sa_we   = cur_valid_reg;
                        tbl_req.sa_addr = cur_slot_reg;
                        tbl_req.sa_val  = pqts_pkg::ST_DEAD;
                        mode_next       = pqts_pkg::PM_EXIT;
                    end
                    pqts_pkg::CMD_YIELD:
                    begin
                        if (!cur_valid_reg)
                        begin
                            mode_next = pqts_pkg::PM_Y0;
                        end
                        else
                        begin
                            mode_next = pqts_pkg::PM_Y;
                            if (active_reg)
                            begin
                                resched_next = 1'b0;
                            end
                        end
                    end
                    pqts_pkg::CMD_UNBLOCK:
                        kind_next = pqts_pkg::SC_FIND_BLK;
                    pqts_pkg::CMD_TICK:
                        kind_next = pqts_pkg::SC_CHOOSE;
                    default:
                        kind_next = pqts_pkg::SC_FIND;
                endcase
            end
            pqts_pkg::S_SCAN:
            begin
                if (scan_issue)
                begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = scan_addr;
                    rd_pend_next    = 1'b1;
                    rd_idx_next     = scan_addr;
                    cnt_next        = cnt_reg + pqts_pkg::CNT_W'(1);
                end
                if (rd_pend_reg)
                begin
                    if (kind_reg == pqts_pkg::SC_CHOOSE)
                    begin
                        if (ev_st == pqts_pkg::ST_READY &&
                            (!found_reg || rd_rec.pri > best_rec_reg.pri))
                        begin
                            found_next    = 1'b1;
                            best_idx_next = rd_idx_reg;
                            best_rec_next = rd_rec;
                        end
                    end
                    else if (!found_reg && rd_rec.id == tid_reg &&
                             (kind_reg != pqts_pkg::SC_FIND_BLK ||
                              ev_st == pqts_pkg::ST_BLOCKED))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = rd_idx_reg;
                        best_rec_next = rd_rec;
                    end
                end
            end
            pqts_pkg::S_PICK:
            begin
                if (found_reg && !(mode_reg == pqts_pkg::PM_Y && pick_same))
                begin
                    // best slot starts running with a fresh quantum
                    cur_valid_next  = 1'b1;
                    cur_slot_next   = best_idx_reg;
                    cur_id_next     = best_rec_reg.id;
                    tbl_req.sa_we   = 1'b1;
                    tbl_req.sa_addr = best_idx_reg;
                    tbl_req.sa_val  = pqts_pkg::ST_RUNNING;
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = best_idx_reg;
                    tbl_req.wr_rec  = best_rec_reg;
                    tbl_req.wr_rec.quantum = quanta[best_rec_reg.pri];
                end
                unique case (mode_reg)
                    pqts_pkg::PM_EXIT:
                    begin
                        if (!found_reg)
                        begin
                            cur_valid_next = 1'b0;
                            cur_slot_next  = '0;
                            cur_id_next    = '0;
                            active_next    = 1'b0;
                        end
                    end
                    pqts_pkg::PM_Y0:
                    begin
                        if (found_reg)
                        begin
                            active_next  = 1'b1;
                            resched_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (!pick_same &&
                            pqts_pkg::status_e'(st_vec[cur_slot_reg]) != pqts_pkg::ST_BLOCKED)
                        begin
                            tbl_req.sb_we   = 1'b1;
                            tbl_req.sb_addr = cur_slot_reg;
                            tbl_req.sb_val  = pqts_pkg::ST_READY;
                        end
                    end
                endcase
            end
            pqts_pkg::S_FOUND:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                start_next = cur_slot_reg;
                kind_next  = pqts_pkg::SC_CHOOSE;
                tbl_req.sa_addr = best_idx_reg;
                if (!found_ok)
                begin
                    rstat_next = pqts_pkg::RS_NOTFOUND;
                end
                else
                begin
                    case (cmd_reg)
                        pqts_pkg::CMD_BLOCK:
                        begin
                            if (f_st == pqts_pkg::ST_READY || f_st == pqts_pkg::ST_RUNNING)
                            begin
                                tbl_req.sa_we  = 1'b1;
                                tbl_req.sa_val = pqts_pkg::ST_BLOCKED;
                                mode_next      = pqts_pkg::PM_Y;
                                if (is_cur && active_reg)
                                begin
                                    resched_next = 1'b0;
                                end
                            end
                        end
                        pqts_pkg::CMD_UNBLOCK:
                        begin
                            tbl_req.sa_we  = 1'b1;
                            tbl_req.sa_val = is_cur ? pqts_pkg::ST_RUNNING
                                                    : pqts_pkg::ST_READY;
                        end
                        pqts_pkg::CMD_KILL:
                        begin
                            tbl_req.sa_we  = 1'b1;
                            tbl_req.sa_val = pqts_pkg::ST_DEAD;
                            mode_next      = pqts_pkg::PM_EXIT;
                        end
                        default:
                        begin
                            fst_next    = f_st;
                            fpri_next   = best_rec_reg.pri;
                            fticks_next = best_rec_reg.ticks;
                        end
                    endcase
                end
            end
            pqts_pkg::S_RD:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = cur_slot_reg;
            end
            pqts_pkg::S_RMW:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = cur_slot_reg;
                tbl_req.wr_rec  = rd_rec;
                tbl_req.wr_rec.id = cur_id_reg;
                if (cmd_reg == pqts_pkg::CMD_TICK)
                begin
                    tbl_req.wr_rec.ticks   = rd_rec.ticks + 32'd1;
                    tbl_req.wr_rec.quantum = tick_q;
                    if (tick_q == 16'd0)
                    begin
                        resched_next = 1'b1;
                    end
                end
                else
                begin
                    tbl_req.wr_rec.quantum = quanta[rd_rec.pri];
                end
            end
            pqts_pkg::S_FIN:
                res_valid = out_free;
            default:
                res_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        res.status          = rstat_reg;
        res.new_id          = new_id_reg;
        res.switched        = (was_valid_reg != cur_valid_reg) ||
                              (cur_valid_reg && was_slot_reg != cur_slot_reg);
        res.has_current     = cur_valid_reg;
        res.current_index   = cur_valid_reg ? pqts_pkg::IDX_W'(cur_slot_reg) : '0;
        res.current_id      = cur_valid_reg ? cur_id_reg : '0;
        res.resched_pending = resched_reg;
        res.found_state     = fst_reg;
        res.found_priority  = fpri_reg;
        res.found_run_ticks = fticks_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pqts_pkg::S_IDLE;
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
            cur_id_reg    <= '0;
            active_reg    <= 1'b0;
            resched_reg   <= 1'b0;
            next_id_reg   <= 32'd1;
            was_valid_reg <= 1'b0;
            was_slot_reg  <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            kind_reg      <= pqts_pkg::SC_FIND;
            mode_reg      <= pqts_pkg::PM_EXIT;
        end
        else
        begin
            state_reg     <= state_next;
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
            cur_id_reg    <= cur_id_next;
            active_reg    <= active_next;
            resched_reg   <= resched_next;
            next_id_reg   <= next_id_next;
            was_valid_reg <= was_valid_next;
            was_slot_reg  <= was_slot_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            kind_reg      <= kind_next;
            mode_reg      <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tid_reg      <= tid_next;
        req_reg      <= req_next;
        rstat_reg    <= rstat_next;
        new_id_reg   <= new_id_next;
        fst_reg      <= fst_next;
        fpri_reg     <= fpri_next;
        fticks_reg   <= fticks_next;
        rd_idx_reg   <= rd_idx_next;
        start_reg    <= start_next;
        best_idx_reg <= best_idx_next;
        best_rec_reg <= best_rec_next;
    end

    `PQTS_IMPLY(a_no_cur_slot_zero, !cur_valid_reg, cur_slot_reg == '0, "slot set with no current")
    `PQTS_IMPLY(a_cur_alive, (state_reg == pqts_pkg::S_IDLE) && cur_valid_reg, st_vec[cur_slot_reg] != pqts_pkg::ST_DEAD, "current thread dead")
    `PQTS_IMPLY(a_pick_ready, (state_reg == pqts_pkg::S_PICK) && found_reg, st_vec[best_idx_reg] == pqts_pkg::ST_READY, "picked slot not ready")
    `PQTS_IMPLY(a_pend_scan, rd_pend_reg, $past(state_reg) == pqts_pkg::S_SCAN, "read data outside scan")

endmodule

// ===== sv/priority_quantum_thread_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// priority_quantum_thread_scheduler_top
// Sixteen-slot priority round-robin thread scheduler with stream channels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries one command beat; master stream m_* returns
//   exactly one result beat per command. Quantum registers are written on
//   cfg_we with cfg_index 0..3 (background, user, system, realtime); other
//   indexes are ignored. Write them only while the block is idle.
//   Create, exit with no current thread and a tick that does nothing use no
//   table scan; a counted tick reads and rewrites the current record. Exit,
//   yield, block, unblock, kill and query scan the table once, and a yield
//   that keeps the current thread then reloads its quantum; blocking or
//   killing the current thread scans twice. The slot record memory gives
//   one read a cycle, so a scan visits one slot a cycle.
//   Commands are handled one at a time; s_tready is high only between them.
//   The result sits in an output register; a stalled m_tready holds it and
//   the block accepts the next beat, stalling only if that one finishes
//   before the first result is taken.
//   Reset: all slots dead, no current thread, next id 1, quanta 5/10/20/40.
//   No clearing pass: unwritten slot ids read zero through per-slot marks.
// ----------------------------------------------------------------------------
module priority_quantum_thread_scheduler_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[2:0], thread_id[34:3], req_priority[42:35]
    input  logic [47:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], new_id[33:2], switched[34], has_current[35],
    // current_index[39:36], current_id[71:40], resched_pending[72],
    // found_state[74:73], found_priority[76:75], found_run_ticks[108:77]
    output logic [111:0] m_tdata,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    pqts_pkg::quanta_t  quanta_reg;
    pqts_pkg::tbl_req_t tbl_req;
    pqts_pkg::rec_t     rd_rec;
    pqts_pkg::st_vec_t  st_vec;
    pqts_pkg::result_t  res;
    pqts_pkg::result_t  out_reg;
    logic               out_valid_reg;
    logic               res_valid;
    logic               out_free;

    // quantum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quanta_reg[0] <= 16'd5;
            quanta_reg[1] <= 16'd10;
            quanta_reg[2] <= 16'd20;
            quanta_reg[3] <= 16'd40;
        end
        else if (cfg_we && cfg_index < 8'(pqts_pkg::NUM_Q))
        begin
            quanta_reg[cfg_index[1:0]] <= cfg_wdata;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    pqts_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_command      (s_tdata[2:0]),
        .in_thread_id    (s_tdata[34:3]),
        .in_req_priority (s_tdata[42:35]),
        .quanta          (quanta_reg),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res             (res),
        .tbl_req         (tbl_req),
        .rd_rec          (rd_rec),
        .st_vec          (st_vec)
    );

    pqts_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_rec  (rd_rec),
        .st_vec  (st_vec)
    );

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule
